>>> sv/ffc_pkg.sv
package ffc_pkg;

  localparam int DW = 32;
  localparam int FB = 20;
  localparam int NW = FB + 2;
  localparam int IW = 3;

  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  localparam int DIV_STEPS  = DW - 1;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int SQRT_STEPS = (DW + FB) / 2;
  localparam int SQRT_PAD   = 2 * SQRT_STEPS - (DW - 1 + FB);
  localparam int SQRT_LAT   = SQRT_STEPS + 1;

  localparam logic [IW-1:0] REG_RHO   = 3'd0;
  localparam logic [IW-1:0] REG_U     = 3'd1;
  localparam logic [IW-1:0] REG_V     = 3'd2;
  localparam logic [IW-1:0] REG_P     = 3'd3;
  localparam logic [IW-1:0] REG_GAMMA = 3'd4;

  localparam logic [DW-2:0] RST_RHO   = 31'd1048576;
  localparam logic [DW-2:0] RST_P     = 31'd748982;
  localparam logic [NW-1:0] RST_GAMMA = 22'd1468006;

  typedef enum logic [1:0] {
    CASE_SUP_IN, CASE_SUP_OUT, CASE_SUB_IN, CASE_SUB_OUT
  } flow_case_t;

  typedef enum logic [1:0] {
    ERR_NONE, ERR_INTERIOR, ERR_FREESTREAM
  } err_t;

  function automatic logic [DW-1:0] fx_abs(input logic [DW-1:0] a);
    return a[DW-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic logic [DW-1:0] ext_n(input logic [NW-1:0] a);
    return {{(DW-NW){a[NW-1]}}, a};
  endfunction

  function automatic logic [DW-1:0] fx_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    return (s[DW] != s[DW-1]) ? (s[DW] ? MINV : MAXV) : s[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] fx_sub(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    return (s[DW] != s[DW-1]) ? (s[DW] ? MINV : MAXV) : s[DW-1:0];
  endfunction

  // truncate toward zero
  function automatic logic [DW-1:0] fx_half(input logic [DW-1:0] a);
    logic [DW:0] s;
    s = {a[DW-1], a} + {{DW{1'b0}}, a[DW-1]};
    return s[DW:1];
  endfunction

  function automatic logic [DW-1:0] fx_mul(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW-1:0] ma, mb, lim, m;
    logic [2*DW-1:0] pr;
    logic [2*DW-FB-1:0] sh;
    logic neg;
    ma = fx_abs(a);
    mb = fx_abs(b);
    pr = {{DW{1'b0}}, ma} * {{DW{1'b0}}, mb};
    sh = pr[2*DW-1:FB];
    neg = a[DW-1] ^ b[DW-1];
    lim = neg ? MINV : MAXV;
    m = (sh > {{(DW-FB){1'b0}}, lim}) ? lim : sh[DW-1:0];
    return neg ? (~m + 1'b1) : m;
  endfunction

endpackage

>>> sv/ffc_if.sv
interface ffc_face_if;
  logic valid;
  logic ready;
  logic signed [ffc_pkg::DW-1:0] interior_density;
  logic signed [ffc_pkg::DW-1:0] interior_u;
  logic signed [ffc_pkg::DW-1:0] interior_v;
  logic signed [ffc_pkg::DW-1:0] interior_pressure;
  logic signed [ffc_pkg::NW-1:0] normal_x;
  logic signed [ffc_pkg::NW-1:0] normal_y;

  modport source (
    output valid, interior_density, interior_u, interior_v, interior_pressure,
           normal_x, normal_y,
    input  ready
  );
  modport sink (
    input  valid, interior_density, interior_u, interior_v, interior_pressure,
           normal_x, normal_y,
    output ready
  );
endinterface

interface ffc_bnd_if;
  logic valid;
  logic ready;
  logic signed [ffc_pkg::DW-1:0] boundary_density;
  logic signed [ffc_pkg::DW-1:0] boundary_u;
  logic signed [ffc_pkg::DW-1:0] boundary_v;
  logic signed [ffc_pkg::DW-1:0] boundary_pressure;
  logic [1:0] flow_case;
  logic [1:0] error_code;

  modport source (
    output valid, boundary_density, boundary_u, boundary_v, boundary_pressure,
           flow_case, error_code,
    input  ready
  );
  modport sink (
    input  valid, boundary_density, boundary_u, boundary_v, boundary_pressure,
           flow_case, error_code,
    output ready
  );
endinterface

>>> sv/ffc_div.sv
module ffc_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ffc_pkg::DW-1:0]   num,
  input  logic [ffc_pkg::DW-1:0]   den,
  output logic [ffc_pkg::DW-1:0]   quo
);

  logic [ffc_pkg::DW-1:0]            na, da;
  logic [ffc_pkg::DW+ffc_pkg::FB-1:0] nfull;
  logic                              ovf, pneg;

  logic [ffc_pkg::DW-1:0]        rem   [0:ffc_pkg::DIV_STEPS];
  logic [ffc_pkg::DIV_STEPS-1:0] nb    [0:ffc_pkg::DIV_STEPS];
  logic [ffc_pkg::DW-1:0]        dv    [0:ffc_pkg::DIV_STEPS];
  logic [ffc_pkg::DIV_STEPS-1:0] qv    [0:ffc_pkg::DIV_STEPS];
  logic                          neg   [0:ffc_pkg::DIV_STEPS];
  logic                          spec  [0:ffc_pkg::DIV_STEPS];
  logic [ffc_pkg::DW-1:0]        sval  [0:ffc_pkg::DIV_STEPS];

  logic [ffc_pkg::DW:0]          trial [0:ffc_pkg::DIV_STEPS-1];
  logic [ffc_pkg::DW:0]          diff  [0:ffc_pkg::DIV_STEPS-1];
  logic                          qb    [0:ffc_pkg::DIV_STEPS-1];
  logic [ffc_pkg::DW-1:0]        qfin;

  always_comb begin
    na = ffc_pkg::fx_abs(num);
    da = ffc_pkg::fx_abs(den);
    pneg = num[ffc_pkg::DW-1] ^ den[ffc_pkg::DW-1];
    nfull = {na, {ffc_pkg::FB{1'b0}}};
    // quotient would not fit below 2^(DW-1); a zero divisor lands here too
    ovf = {{(ffc_pkg::DW-1-ffc_pkg::FB){1'b0}}, nfull} >= {da, {(ffc_pkg::DW-1){1'b0}}};
    for (int k = 0; k < ffc_pkg::DIV_STEPS; k++) begin
      trial[k] = {rem[k], nb[k][ffc_pkg::DIV_STEPS-1]};
      diff[k]  = trial[k] - {1'b0, dv[k]};
      qb[k]    = trial[k] >= {1'b0, dv[k]};
    end
    qfin = {1'b0, qv[ffc_pkg::DIV_STEPS]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {{(ffc_pkg::DW-ffc_pkg::FB-1){1'b0}},
                  nfull[ffc_pkg::DW+ffc_pkg::FB-1:ffc_pkg::DW-1]};
      nb[0]   <= nfull[ffc_pkg::DW-2:0];
      dv[0]   <= da;
      qv[0]   <= '0;
      neg[0]  <= pneg;
      spec[0] <= ovf;
      sval[0] <= (na == '0) ? '0 : (pneg ? ffc_pkg::MINV : ffc_pkg::MAXV);
      for (int k = 0; k < ffc_pkg::DIV_STEPS; k++) begin
        rem[k+1]  <= qb[k] ? diff[k][ffc_pkg::DW-1:0] : trial[k][ffc_pkg::DW-1:0];
        nb[k+1]   <= {nb[k][ffc_pkg::DIV_STEPS-2:0], 1'b0};
        dv[k+1]   <= dv[k];
        qv[k+1]   <= {qv[k][ffc_pkg::DIV_STEPS-2:0], qb[k]};
        neg[k+1]  <= neg[k];
        spec[k+1] <= spec[k];
        sval[k+1] <= sval[k];
      end
      quo <= spec[ffc_pkg::DIV_STEPS] ? sval[ffc_pkg::DIV_STEPS]
           : (neg[ffc_pkg::DIV_STEPS] ? (~qfin + 1'b1) : qfin);
    end
  end

endmodule

>>> sv/ffc_sqrt.sv
module ffc_sqrt (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ffc_pkg::DW-1:0] x,
  output logic [ffc_pkg::DW-1:0] root
);

  logic [ffc_pkg::DW-1:0]           xs;
  logic [2*ffc_pkg::SQRT_STEPS-1:0] xb   [0:ffc_pkg::SQRT_STEPS];
  logic [ffc_pkg::SQRT_STEPS+1:0]   rem  [0:ffc_pkg::SQRT_STEPS];
  logic [ffc_pkg::SQRT_STEPS-1:0]   rt   [0:ffc_pkg::SQRT_STEPS];

  logic [ffc_pkg::SQRT_STEPS+3:0]   tr   [0:ffc_pkg::SQRT_STEPS-1];
  logic [ffc_pkg::SQRT_STEPS+3:0]   tv   [0:ffc_pkg::SQRT_STEPS-1];
  logic [ffc_pkg::SQRT_STEPS+3:0]   td   [0:ffc_pkg::SQRT_STEPS-1];
  logic                             ge   [0:ffc_pkg::SQRT_STEPS-1];

  always_comb begin
    // zero for non-positive operands
    xs = (x[ffc_pkg::DW-1] || x == '0) ? '0 : x;
    for (int k = 0; k < ffc_pkg::SQRT_STEPS; k++) begin
      tr[k] = {rem[k], xb[k][2*ffc_pkg::SQRT_STEPS-1 -: 2]};
      tv[k] = {2'b00, rt[k], 2'b01};
      td[k] = tr[k] - tv[k];
      ge[k] = tr[k] >= tv[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xb[0]  <= {{ffc_pkg::SQRT_PAD{1'b0}}, xs[ffc_pkg::DW-2:0], {ffc_pkg::FB{1'b0}}};
      rem[0] <= '0;
      rt[0]  <= '0;
      for (int k = 0; k < ffc_pkg::SQRT_STEPS; k++) begin
        xb[k+1]  <= {xb[k][2*ffc_pkg::SQRT_STEPS-3:0], 2'b00};
        rem[k+1] <= ge[k] ? td[k][ffc_pkg::SQRT_STEPS+1:0] : tr[k][ffc_pkg::SQRT_STEPS+1:0];
        rt[k+1]  <= {rt[k][ffc_pkg::SQRT_STEPS-2:0], ge[k]};
      end
    end
  end

  assign root = {{(ffc_pkg::DW-ffc_pkg::SQRT_STEPS){1'b0}}, rt[ffc_pkg::SQRT_STEPS]};

endmodule

>>> sv/farfield_characteristic_state_core.sv
// channel  | dir | transfer when     | payload
// ---------+-----+-------------------+------------------------------------------------
// face     | in  | valid && ready    | interior density/u/v/pressure, normal x/y
// bnd      | out | valid && ready    | boundary density/u/v/pressure, flow_case, error
// cfg      | in  | cfg_write         | cfg_index selects register, cfg_data
//
// One face per cycle unless the output stalls; values are Q12.20 fixed point.
// The pipeline depth is set by the two chains of bit-per-stage dividers and the square-root units.
// Reset (rst, synchronous) clears every valid bit and loads the freestream defaults.
// The whole pipeline holds while a result waits at the output and bnd.ready is low.
module farfield_characteristic_state_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [ffc_pkg::IW-1:0] cfg_index,
  input  logic [ffc_pkg::DW-1:0] cfg_data,
  ffc_face_if.sink               face,
  ffc_bnd_if.source              bnd
);

  typedef struct packed {
    logic [ffc_pkg::DW-1:0] ri, ui, vi, pi;
    logic [ffc_pkg::DW-1:0] nx, ny;
    ffc_pkg::err_t          err;
    logic [ffc_pkg::DW-1:0] gpi, gpf, uinx, viny, ufnx, vfny, uu, vv;
    logic [ffc_pkg::DW-1:0] vinx, uiny, vfnx, ufny;
    logic [ffc_pkg::DW-1:0] uni, unf, uti, utf, vsq;
    logic                   sup, inflow;
    logic [ffc_pkg::DW-1:0] riai, aiai, afaf, rfaf, dun, t, pb, den_r, den_u, nr, nu;
    logic [ffc_pkg::DW-1:0] rb, unb, ut, p_unx, p_uty, p_uny, p_utx;
  } ctx_t;

  logic [ffc_pkg::DW-2:0] cfg_rho, cfg_p;
  logic [ffc_pkg::DW-1:0] cfg_u, cfg_v;
  logic [ffc_pkg::NW-1:0] cfg_gamma;
  logic [ffc_pkg::DW-1:0] rf, pf, gx;

  logic en;
  logic v1, v2, vm1, vm2, vm3, vm4, vn1, vn2;
  logic vd [0:ffc_pkg::DIV_LAT-1];
  logic vs [0:ffc_pkg::SQRT_LAT-1];
  logic ve [0:ffc_pkg::DIV_LAT-1];

  ctx_t c1, c2, m1, m2, m3, m4, n1, n2;
  ctx_t c1_next, c2_next, m1_next, m2_next, m3_next, m4_next, n1_next, n2_next;
  ctx_t dctx [0:ffc_pkg::DIV_LAT-1];
  ctx_t sctx [0:ffc_pkg::SQRT_LAT-1];
  ctx_t ectx [0:ffc_pkg::DIV_LAT-1];

  logic [ffc_pkg::DW-1:0] q_gi, q_gf, sq_ai, sq_af, sq_vm, q_r, q_u;
  logic [ffc_pkg::DW-1:0] o_rho, o_u, o_v, o_p, bu, bv;
  ffc_pkg::flow_case_t    o_case;

  assign rf = {1'b0, cfg_rho};
  assign pf = {1'b0, cfg_p};
  assign gx = {{(ffc_pkg::DW-ffc_pkg::NW){1'b0}}, cfg_gamma};

  assign en         = !bnd.valid || bnd.ready;
  assign face.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_rho   <= ffc_pkg::RST_RHO;
      cfg_u     <= '0;
      cfg_v     <= '0;
      cfg_p     <= ffc_pkg::RST_P;
      cfg_gamma <= ffc_pkg::RST_GAMMA;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ffc_pkg::REG_RHO:   cfg_rho   <= cfg_data[ffc_pkg::DW-2:0];
        ffc_pkg::REG_U:     cfg_u     <= cfg_data;
        ffc_pkg::REG_V:     cfg_v     <= cfg_data;
        ffc_pkg::REG_P:     cfg_p     <= cfg_data[ffc_pkg::DW-2:0];
        ffc_pkg::REG_GAMMA: cfg_gamma <= cfg_data[ffc_pkg::NW-1:0];
        default: ;
      endcase
    end
  end

  // products and error checks
  always_comb begin
    c1_next    = '0;
    c1_next.ri = face.interior_density;
    c1_next.ui = face.interior_u;
    c1_next.vi = face.interior_v;
    c1_next.pi = face.interior_pressure;
    c1_next.nx = ffc_pkg::ext_n(face.normal_x);
    c1_next.ny = ffc_pkg::ext_n(face.normal_y);
    if (c1_next.ri[ffc_pkg::DW-1] || c1_next.ri == '0 ||
        c1_next.pi[ffc_pkg::DW-1] || c1_next.pi == '0) begin
      c1_next.err = ffc_pkg::ERR_INTERIOR;
    end else if (cfg_rho == '0 || cfg_p == '0) begin
      c1_next.err = ffc_pkg::ERR_FREESTREAM;
    end else begin
      c1_next.err = ffc_pkg::ERR_NONE;
    end
    c1_next.gpi  = ffc_pkg::fx_mul(gx, c1_next.pi);
    c1_next.gpf  = ffc_pkg::fx_mul(gx, pf);
    c1_next.uinx = ffc_pkg::fx_mul(c1_next.ui, c1_next.nx);
    c1_next.viny = ffc_pkg::fx_mul(c1_next.vi, c1_next.ny);
    c1_next.ufnx = ffc_pkg::fx_mul(cfg_u, c1_next.nx);
    c1_next.vfny = ffc_pkg::fx_mul(cfg_v, c1_next.ny);
    c1_next.uu   = ffc_pkg::fx_mul(c1_next.ui, c1_next.ui);
    c1_next.vv   = ffc_pkg::fx_mul(c1_next.vi, c1_next.vi);
    c1_next.vinx = ffc_pkg::fx_mul(c1_next.vi, c1_next.nx);
    c1_next.uiny = ffc_pkg::fx_mul(c1_next.ui, c1_next.ny);
    c1_next.vfnx = ffc_pkg::fx_mul(cfg_v, c1_next.nx);
    c1_next.ufny = ffc_pkg::fx_mul(cfg_u, c1_next.ny);
  end

  always_comb begin
    c2_next     = c1;
    c2_next.uni = ffc_pkg::fx_add(c1.uinx, c1.viny);
    c2_next.unf = ffc_pkg::fx_add(c1.ufnx, c1.vfny);
    c2_next.vsq = ffc_pkg::fx_add(c1.uu, c1.vv);
    c2_next.uti = ffc_pkg::fx_sub(c1.vinx, c1.uiny);
    c2_next.utf = ffc_pkg::fx_sub(c1.vfnx, c1.ufny);
  end

  ffc_div u_div_gi (.clk(clk), .en(en), .num(c2.gpi), .den(c2.ri), .quo(q_gi));
  ffc_div u_div_gf (.clk(clk), .en(en), .num(c2.gpf), .den(rf),    .quo(q_gf));

  ffc_sqrt u_sqrt_ai (.clk(clk), .en(en), .x(q_gi), .root(sq_ai));
  ffc_sqrt u_sqrt_af (.clk(clk), .en(en), .x(q_gf), .root(sq_af));
  ffc_sqrt u_sqrt_vm (.clk(clk), .en(en), .x(dctx[ffc_pkg::DIV_LAT-1].vsq), .root(sq_vm));

  always_comb begin
    m1_next        = sctx[ffc_pkg::SQRT_LAT-1];
    m1_next.sup    = sq_vm >= sq_ai;
    m1_next.inflow = m1_next.uni[ffc_pkg::DW-1];
    m1_next.riai   = ffc_pkg::fx_mul(m1_next.ri, sq_ai);
    m1_next.aiai   = ffc_pkg::fx_mul(sq_ai, sq_ai);
    m1_next.afaf   = ffc_pkg::fx_mul(sq_af, sq_af);
    m1_next.rfaf   = ffc_pkg::fx_mul(rf, sq_af);
    m1_next.dun    = ffc_pkg::fx_sub(m1_next.unf, m1_next.uni);
  end

  always_comb begin
    m2_next   = m1;
    m2_next.t = ffc_pkg::fx_mul(m1.riai, m1.dun);
  end

  always_comb begin
    m3_next       = m2;
    m3_next.pb    = m2.inflow
                    ? ffc_pkg::fx_half(ffc_pkg::fx_sub(ffc_pkg::fx_add(pf, m2.pi), m2.t))
                    : pf;
    m3_next.den_r = m2.inflow ? m2.afaf : m2.aiai;
    m3_next.den_u = m2.inflow ? m2.rfaf : m2.riai;
  end

  always_comb begin
    m4_next    = m3;
    m4_next.nr = m3.inflow ? ffc_pkg::fx_sub(m3.pb, pf) : ffc_pkg::fx_sub(m3.pb, m3.pi);
    m4_next.nu = m3.inflow ? ffc_pkg::fx_sub(pf, m3.pb) : ffc_pkg::fx_sub(m3.pi, m3.pb);
  end

  ffc_div u_div_r (.clk(clk), .en(en), .num(m4.nr), .den(m4.den_r), .quo(q_r));
  ffc_div u_div_u (.clk(clk), .en(en), .num(m4.nu), .den(m4.den_u), .quo(q_u));

  always_comb begin
    n1_next     = ectx[ffc_pkg::DIV_LAT-1];
    n1_next.rb  = ffc_pkg::fx_add(n1_next.inflow ? rf : n1_next.ri, q_r);
    n1_next.unb = n1_next.inflow ? ffc_pkg::fx_sub(n1_next.unf, q_u)
                                 : ffc_pkg::fx_add(n1_next.uni, q_u);
    n1_next.ut  = n1_next.inflow ? n1_next.utf : n1_next.uti;
  end

  always_comb begin
    n2_next       = n1;
    n2_next.p_unx = ffc_pkg::fx_mul(n1.unb, n1.nx);
    n2_next.p_uty = ffc_pkg::fx_mul(n1.ut, n1.ny);
    n2_next.p_uny = ffc_pkg::fx_mul(n1.unb, n1.ny);
    n2_next.p_utx = ffc_pkg::fx_mul(n1.ut, n1.nx);
  end

  always_comb begin
    bu = ffc_pkg::fx_sub(n2.p_unx, n2.p_uty);
    bv = ffc_pkg::fx_add(n2.p_uny, n2.p_utx);
    priority if (n2.err != ffc_pkg::ERR_NONE) begin
      o_rho = '0; o_u = '0; o_v = '0; o_p = '0;
      o_case = ffc_pkg::CASE_SUP_IN;
    end else if (n2.sup && n2.inflow) begin
      o_rho = rf; o_u = cfg_u; o_v = cfg_v; o_p = pf;
      o_case = ffc_pkg::CASE_SUP_IN;
    end else if (n2.sup) begin
      o_rho = n2.ri; o_u = n2.ui; o_v = n2.vi; o_p = n2.pi;
      o_case = ffc_pkg::CASE_SUP_OUT;
    end else begin
      o_rho = n2.rb; o_u = bu; o_v = bv; o_p = n2.pb;
      o_case = n2.inflow ? ffc_pkg::CASE_SUB_IN : ffc_pkg::CASE_SUB_OUT;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0;
      vm1 <= 1'b0; vm2 <= 1'b0; vm3 <= 1'b0; vm4 <= 1'b0;
      vn1 <= 1'b0; vn2 <= 1'b0;
      bnd.valid <= 1'b0;
      for (int k = 0; k < ffc_pkg::DIV_LAT; k++) begin
        vd[k] <= 1'b0;
        ve[k] <= 1'b0;
      end
      for (int k = 0; k < ffc_pkg::SQRT_LAT; k++) begin
        vs[k] <= 1'b0;
      end
    end else if (en) begin
      v1 <= face.valid;
      v2 <= v1;
      vd[0] <= v2;
      for (int k = 1; k < ffc_pkg::DIV_LAT; k++) vd[k] <= vd[k-1];
      vs[0] <= vd[ffc_pkg::DIV_LAT-1];
      for (int k = 1; k < ffc_pkg::SQRT_LAT; k++) vs[k] <= vs[k-1];
      vm1 <= vs[ffc_pkg::SQRT_LAT-1];
      vm2 <= vm1;
      vm3 <= vm2;
      vm4 <= vm3;
      ve[0] <= vm4;
      for (int k = 1; k < ffc_pkg::DIV_LAT; k++) ve[k] <= ve[k-1];
      vn1 <= ve[ffc_pkg::DIV_LAT-1];
      vn2 <= vn1;
      bnd.valid <= vn2;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= c1_next;
      c2 <= c2_next;
      dctx[0] <= c2;
      for (int k = 1; k < ffc_pkg::DIV_LAT; k++) dctx[k] <= dctx[k-1];
      sctx[0] <= dctx[ffc_pkg::DIV_LAT-1];
      for (int k = 1; k < ffc_pkg::SQRT_LAT; k++) sctx[k] <= sctx[k-1];
      m1 <= m1_next;
      m2 <= m2_next;
      m3 <= m3_next;
      m4 <= m4_next;
      ectx[0] <= m4;
      for (int k = 1; k < ffc_pkg::DIV_LAT; k++) ectx[k] <= ectx[k-1];
      n1 <= n1_next;
      n2 <= n2_next;
      bnd.boundary_density  <= o_rho;
      bnd.boundary_u        <= o_u;
      bnd.boundary_v        <= o_v;
      bnd.boundary_pressure <= o_p;
      bnd.flow_case         <= o_case;
      bnd.error_code        <= n2.err;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    bnd.valid && bnd.error_code != ffc_pkg::ERR_NONE |->
      bnd.boundary_density == '0 && bnd.boundary_u == '0 &&
      bnd.boundary_v == '0 && bnd.boundary_pressure == '0)
    else $error("error result carries non-zero state");

  a_err_case: assert property (@(posedge clk) disable iff (rst)
    bnd.valid && bnd.error_code != ffc_pkg::ERR_NONE |->
      bnd.flow_case == ffc_pkg::CASE_SUP_IN)
    else $error("error result carries a flow case");

  a_sqrt_sign: assert property (@(posedge clk) disable iff (rst)
    vs[ffc_pkg::SQRT_LAT-1] |->
      !sq_ai[ffc_pkg::DW-1] && !sq_af[ffc_pkg::DW-1] && !sq_vm[ffc_pkg::DW-1])
    else $error("square root produced a negative value");

endmodule

>>> tb/farfield_characteristic_state_checker.sv
module farfield_characteristic_state_checker
  import ffc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [IW-1:0]    cfg_index,
  input  logic [DW-1:0]    cfg_data,
  ffc_face_if              face,
  ffc_bnd_if               bnd,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DW-1:0] rho;
    logic [DW-1:0] u;
    logic [DW-1:0] v;
    logic [DW-1:0] p;
    flow_case_t    fcase;
    err_t          err;
  } bstate_t;

  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;

  longint fs_rho, fs_u, fs_v, fs_p, fs_gamma;
  bstate_t boundary_q[$];

  function automatic longint clip(input longint a);
    return a > SMAX ? SMAX : (a < SMIN ? SMIN : a);
  endfunction

  function automatic longint q_add(input longint a, input longint b);
    return clip(a + b);
  endfunction

  function automatic longint q_sub(input longint a, input longint b);
    return clip(a - b);
  endfunction

  function automatic longint q_mul(input longint a, input longint b);
    logic [127:0] m;
    logic neg;
    neg = (a < 0) != (b < 0);
    m = (128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b)) >> FB;
    if (neg) return (m > 128'(-SMIN)) ? SMIN : -longint'(m);
    return (m > 128'(SMAX)) ? SMAX : longint'(m);
  endfunction

  function automatic longint q_div(input longint a, input longint b);
    logic [127:0] qt;
    logic neg;
    if (b == 0) return a == 0 ? 0 : (a < 0 ? SMIN : SMAX);
    neg = (a < 0) != (b < 0);
    qt = (128'(a < 0 ? -a : a) << FB) / 128'(b < 0 ? -b : b);
    if (neg) return (qt > 128'(-SMIN)) ? SMIN : -longint'(qt);
    return (qt > 128'(SMAX)) ? SMAX : longint'(qt);
  endfunction

  function automatic longint q_sqrt(input longint x);
    logic [127:0] xs, c;
    logic [63:0] r;
    if (x <= 0) return 0;
    xs = 128'(x) << FB;
    r = 0;
    for (int i = 40; i >= 0; i--) begin
      c = 128'(r | (64'd1 << i));
      if (c * c <= xs) r = r | (64'd1 << i);
    end
    return longint'(r);
  endfunction

  function automatic bstate_t boundary_of(input longint ri, ui, vi, pi, nx, ny);
    bstate_t o;
    longint ai, af, uni, unf, vmag, pb, rb, unb, ut, t;
    o = '0;
    o.fcase = CASE_SUP_IN;
    o.err = ERR_NONE;
    if (ri <= 0 || pi <= 0) begin
      o.err = ERR_INTERIOR;
      return o;
    end
    if (fs_rho <= 0 || fs_p <= 0) begin
      o.err = ERR_FREESTREAM;
      return o;
    end
    ai = q_sqrt(q_div(q_mul(fs_gamma, pi), ri));
    af = q_sqrt(q_div(q_mul(fs_gamma, fs_p), fs_rho));
    uni = q_add(q_mul(ui, nx), q_mul(vi, ny));
    unf = q_add(q_mul(fs_u, nx), q_mul(fs_v, ny));
    vmag = q_sqrt(q_add(q_mul(ui, ui), q_mul(vi, vi)));
    if (vmag >= ai) begin
      if (uni < 0) begin
        o.fcase = CASE_SUP_IN;
        o.rho = fs_rho; o.u = fs_u; o.v = fs_v; o.p = fs_p;
      end else begin
        o.fcase = CASE_SUP_OUT;
        o.rho = ri; o.u = ui; o.v = vi; o.p = pi;
      end
      return o;
    end
    if (uni < 0) begin
      o.fcase = CASE_SUB_IN;
      t = q_mul(q_mul(ri, ai), q_sub(unf, uni));
      pb = q_sub(q_add(fs_p, pi), t) / 2;
      rb = q_add(fs_rho, q_div(q_sub(pb, fs_p), q_mul(af, af)));
      unb = q_sub(unf, q_div(q_sub(fs_p, pb), q_mul(fs_rho, af)));
      ut = q_sub(q_mul(fs_v, nx), q_mul(fs_u, ny));
    end else begin
      o.fcase = CASE_SUB_OUT;
      pb = fs_p;
      rb = q_add(ri, q_div(q_sub(pb, pi), q_mul(ai, ai)));
      unb = q_add(uni, q_div(q_sub(pi, pb), q_mul(ri, ai)));
      ut = q_sub(q_mul(vi, nx), q_mul(ui, ny));
    end
    o.rho = rb;
    o.u = q_sub(q_mul(unb, nx), q_mul(ut, ny));
    o.v = q_add(q_mul(unb, ny), q_mul(ut, nx));
    o.p = pb;
    return o;
  endfunction

  assign pending = boundary_q.size();

  always @(posedge clk) begin
    bstate_t want;
    if (rst) begin
      fs_rho <= RST_RHO;
      fs_u <= 0;
      fs_v <= 0;
      fs_p <= RST_P;
      fs_gamma <= RST_GAMMA;
      fail_count <= 0;
      boundary_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_RHO:   fs_rho <= longint'(cfg_data[DW-2:0]);
          REG_U:     fs_u <= longint'($signed(cfg_data));
          REG_V:     fs_v <= longint'($signed(cfg_data));
          REG_P:     fs_p <= longint'(cfg_data[DW-2:0]);
          REG_GAMMA: fs_gamma <= longint'(cfg_data[NW-1:0]);
          default: ;
        endcase
      end
      if (face.valid && face.ready)
        boundary_q.push_back(boundary_of(face.interior_density, face.interior_u,
          face.interior_v, face.interior_pressure, face.normal_x, face.normal_y));
      if (bnd.valid && bnd.ready) begin
        if (boundary_q.size() == 0) begin
          $error("boundary transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = boundary_q.pop_front();
          if (bnd.boundary_density !== want.rho || bnd.boundary_u !== want.u ||
              bnd.boundary_v !== want.v || bnd.boundary_pressure !== want.p ||
              bnd.flow_case !== want.fcase || bnd.error_code !== want.err) begin
            fail_count <= fail_count + 1;
            if (bnd.boundary_density !== want.rho)
              $error("boundary_density: expected %0d, got %0d",
                $signed(want.rho), bnd.boundary_density);
            if (bnd.boundary_u !== want.u)
              $error("boundary_u: expected %0d, got %0d", $signed(want.u), bnd.boundary_u);
            if (bnd.boundary_v !== want.v)
              $error("boundary_v: expected %0d, got %0d", $signed(want.v), bnd.boundary_v);
            if (bnd.boundary_pressure !== want.p)
              $error("boundary_pressure: expected %0d, got %0d",
                $signed(want.p), bnd.boundary_pressure);
            if (bnd.flow_case !== want.fcase)
              $error("flow_case: expected %0d, got %0d", want.fcase, bnd.flow_case);
            if (bnd.error_code !== want.err)
              $error("error_code: expected %0d, got %0d", want.err, bnd.error_code);
          end
        end
      end
    end
  end
endmodule

>>> tb/farfield_characteristic_state_core_test.sv
module farfield_characteristic_state_core_test;
  import ffc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 2 * DIV_LAT + SQRT_LAT + 9;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [IW-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_data = '0;
  int fail_count, pending;
  int idle_cycles = 0;
  bit sink_hold = 1'b0;
  bit stim_done = 1'b0;

  ffc_face_if face ();
  ffc_bnd_if bnd ();

  farfield_characteristic_state_core dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .face(face.sink), .bnd(bnd.source)
  );

  farfield_characteristic_state_checker checker_i (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .face(face), .bnd(bnd),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    face.valid = 1'b0;
    face.interior_density = '0;
    face.interior_u = '0;
    face.interior_v = '0;
    face.interior_pressure = '0;
    face.normal_x = '0;
    face.normal_y = '0;
    bnd.ready = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(negedge clk) begin
    int n;
    if (rst) begin
      bnd.ready <= 1'b0;
    end else if (sink_hold) begin
      bnd.ready <= 1'b0;
    end else begin
      n = gap_len();
      if (n == 0) begin
        bnd.ready <= 1'b1;
      end else begin
        bnd.ready <= 1'b0;
        repeat (n) @(negedge clk);
        bnd.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (face.valid && face.ready) || (bnd.valid && bnd.ready))
      idle_cycles <= 0;
    else if (stim_done || face.valid || pending > 0 || sink_hold)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_face(input logic [DW-1:0] rho, u, v, p, input logic [NW-1:0] nx, ny);
    face.valid <= 1'b1;
    face.interior_density <= rho;
    face.interior_u <= u;
    face.interior_v <= v;
    face.interior_pressure <= p;
    face.normal_x <= nx;
    face.normal_y <= ny;
    @(posedge clk);
    while (!face.ready) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      face.valid <= 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    face.valid <= 1'b0;
    while (pending > 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  function automatic logic [NW-1:0] rand_normal();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return NW'($urandom);
    if (r == 1) return (r & 1) ? NW'(1048576) : NW'(-1048576);
    return NW'($signed($urandom_range(0, 2097152)) - 1048576);
  endfunction

  // Mostly physical states near unit scale, some wild values.
  function automatic logic [DW-1:0] rand_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return MAXV;
    return $urandom_range(1, 8 << FB);
  endfunction

  function automatic logic [DW-1:0] rand_vel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r < 5) return DW'($signed($urandom_range(0, 6 << FB)) - (3 << FB));
    return DW'($signed($urandom_range(0, 1 << FB)) - (1 << (FB - 1)));
  endfunction

  task automatic random_faces(input int n);
    repeat (n)
      send_face(rand_pos(), rand_vel(), rand_vel(), rand_pos(), rand_normal(), rand_normal());
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, interior errors, each flow regime
    send_face(0, 0, 0, 1 << FB, 1 << FB, 0);
    send_face(1 << FB, 0, 0, 0, 1 << FB, 0);
    send_face(MINV, MINV, MAXV, MINV, -(1 << FB), 0);
    send_face(MAXV, MAXV, MINV, MAXV, NW'(1 << FB), NW'(-(1 << FB)));
    send_face(1 << FB, 3 << FB, 0, 748982, 1 << FB, 0);
    send_face(1 << FB, 3 << FB, 0, 748982, -(1 << FB), 0);
    send_face(1 << FB, 1 << (FB - 2), 0, 748982, 1 << FB, 0);
    send_face(1 << FB, 1 << (FB - 2), 0, 748982, -(1 << FB), 0);
    send_face(1 << FB, 0, 1 << (FB - 3), 1 << FB, 0, -(1 << FB));
    send_face(1, 1, 1, 1, NW'(-2097152), NW'(2097151));
    send_face(MAXV, 0, 0, 1, 0, 0);
    send_face(1 << FB, MAXV, MAXV, 1 << FB, 741455, 741455);
    send_face(1 << FB, 1 << FB, 0, 1 << FB, '1, NW'(1 << (NW - 2)));
    drain();

    write_reg(REG_RHO, 0);
    send_face(1 << FB, 0, 0, 1 << FB, 1 << FB, 0);
    drain();
    write_reg(REG_RHO, {1'b1, {(DW-1){1'b1}}});
    write_reg(REG_P, 0);
    send_face(1 << FB, 0, 0, 1 << FB, 1 << FB, 0);
    drain();
    write_reg(REG_P, MAXV);
    write_reg(REG_U, MINV);
    write_reg(REG_V, MAXV);
    write_reg(REG_GAMMA, 1048577);
    write_reg(3'd7, $urandom);
    random_faces(80);
    drain();

    write_reg(REG_RHO, 1 << FB);
    write_reg(REG_P, 748982);
    write_reg(REG_U, 1 << (FB - 1));
    write_reg(REG_V, -(1 << (FB - 2)));
    write_reg(REG_GAMMA, 2097152);
    random_faces(250);
    // pause on the sender side until everything is back
    drain();

    write_reg(REG_GAMMA, 22'h3FFFFF);
    write_reg(REG_U, $urandom);
    write_reg(REG_V, $urandom);
    fork
      begin
        sink_hold = 1'b1;
        repeat (300) @(negedge clk);
        sink_hold = 1'b0;
      end
      random_faces(200);
    join
    drain();

    write_reg(REG_RHO, $urandom_range(1 << (FB - 2), 4 << FB));
    write_reg(REG_P, $urandom_range(1 << (FB - 2), 4 << FB));
    write_reg(REG_U, 0);
    write_reg(REG_V, 0);
    write_reg(REG_GAMMA, 1468006);
    random_faces(350);
    drain();

    stim_done = 1'b1;
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

>>> files.f
sv/ffc_pkg.sv
sv/ffc_if.sv
sv/ffc_div.sv
sv/ffc_sqrt.sv
sv/farfield_characteristic_state_core.sv
tb/farfield_characteristic_state_checker.sv
tb/farfield_characteristic_state_core_test.sv
